// ===== rtl/core/ssfd_pkg.sv =====
// Shared types and constants for the start/stop frame deframer.
// No dependencies; imported by every module in rtl/core.
package ssfd_pkg;

  localparam logic [7:0] START_BYTE   = 8'hFF;
  localparam logic [7:0] STOP_BYTE    = 8'hFE;
  localparam int unsigned MARKER_BIT  = 6;
  localparam logic [7:0] CMD_FRONT    = 8'd11;
  localparam logic [7:0] CMD_LEFT     = 8'd12;
  localparam logic [7:0] CMD_RIGHT    = 8'd13;

  localparam int unsigned RX_W  = 8;
  localparam int unsigned CMD_W = 8;
  localparam int unsigned VAL_W = 16;

  // Frame phase: idle, waiting for payload bytes 1..4, waiting for stop.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_B1   = 3'd1,
    PH_B2   = 3'd2,
    PH_B3   = 3'd3,
    PH_B4   = 3'd4,
    PH_STOP = 3'd5
  } phase_e;

  // Result item; command sits in the lowest bits when packed.
  typedef struct packed {
    logic [VAL_W-1:0] right_distance;
    logic [VAL_W-1:0] left_distance;
    logic [VAL_W-1:0] front_distance;
    logic [VAL_W-1:0] value;
    logic [CMD_W-1:0] command;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

  // Input stage to frame engine.
  typedef struct packed {
    logic            valid;
    logic [RX_W-1:0] rx_byte;
  } in_item_t;

endpackage

// ===== rtl/core/start_stop_frame_deframer_top.sv =====
// Top level of the start/stop framed byte deframer with sensor latches.
// Depends on ssfd_pkg, ssfd_in_reg, ssfd_core and ssfd_out_reg.
//
// Usage:
//   Slave channel: one received serial byte per item on s_axis_tdata_i.
//   Frames are 0xFF, cmd, b2, b3, b4, 0xFE. A 0xFF byte restarts capture
//   in any phase. A frame is emitted only on a good stop byte with bit 6
//   of b2 set; anything else is dropped silently.
//   Master channel: one item per good frame carrying the command, the
//   decoded 16-bit value and the front/left/right sensor registers after
//   this frame's update (commands 11/12/13 load them).
// Timing:
//   One byte per cycle sustained, unless a frame's result finds the output
//   register full. A byte is held in the input register and decoded from it
//   combinationally; a frame's result is registered in the output register.
// Reset:
//   rst_ni clears the phase to idle, the sensor registers to zero and
//   both stage valids; payload bytes are not reset.
// Stall:
//   While a result waits in the output register, bytes that finish no frame
//   keep flowing. A byte that completes a frame waits in the input register
//   until the output register is free, and the slave tready drops then.
module start_stop_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // [7:0] command, [23:8] value,
                                        // [39:24] front_distance,
                                        // [55:40] left_distance,
                                        // [71:56] right_distance
);
  import ssfd_pkg::*;

  in_item_t item;
  result_t  result;
  logic     hit;
  logic     out_free;
  logic     step;

  // held byte moves on unless it makes a result that has nowhere to go
  assign step = item.valid && (!hit || out_free);

  ssfd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_data_i  (s_axis_tdata_i),
    .take_i    (step),
    .item_o    (item)
  );

  ssfd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .step_i   (step),
    .hit_o    (hit),
    .result_o (result)
  );

  ssfd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (step && hit),
    .result_i  (result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== rtl/core/ssfd_in_reg.sv =====
// Input register stage of the deframer.
// Depends on ssfd_pkg.
module ssfd_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [7:0]         s_data_i,
  input  logic               take_i,    // downstream consumes held item
  output ssfd_pkg::in_item_t item_o
);
  import ssfd_pkg::*;

  logic            valid_q, valid_d;
  logic [RX_W-1:0] data_q;
  logic            load;

  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= s_data_i;
    end
  end

  assign item_o.valid   = valid_q;
  assign item_o.rx_byte = data_q;

endmodule

// ===== rtl/core/ssfd_core.sv =====
// Frame engine: phase tracking, payload capture, value decode, sensor latches.
// Depends on ssfd_pkg.
module ssfd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssfd_pkg::in_item_t item_i,
  input  logic               step_i,   // commit the held item this cycle
  output logic               hit_o,    // held item completes a good frame
  output ssfd_pkg::result_t  result_o
);
  import ssfd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [RX_W-1:0]  pay_q [4];
  logic [VAL_W-1:0] front_q, front_d;
  logic [VAL_W-1:0] left_q, left_d;
  logic [VAL_W-1:0] right_q, right_d;
  logic [VAL_W-1:0] value;
  logic [RX_W-1:0]  b;
  logic             good;

  assign b = item_i.rx_byte;

  // byte4 | (byte3 & 0x3F) << 6 | (byte2 & 0x3F) << 12, kept to 16 bits
  assign value = {8'h00, pay_q[3]}
               | {4'h0, pay_q[2][5:0], 6'h00}
               | {pay_q[1][3:0], 12'h000};

  always_comb begin
    phase_d = PH_IDLE;
    good    = 1'b0;
    case (phase_q)
      PH_B1:   phase_d = PH_B2;
      PH_B2:   phase_d = PH_B3;
      PH_B3:   phase_d = PH_B4;
      PH_B4:   phase_d = PH_STOP;
      PH_STOP: good = (b == STOP_BYTE) && pay_q[1][MARKER_BIT];
      default: phase_d = PH_IDLE;
    endcase
    // start byte restarts capture from any phase
    if (b == START_BYTE) begin
      phase_d = PH_B1;
    end
  end

  assign hit_o = item_i.valid && good;

  always_comb begin
    front_d = front_q;
    left_d  = left_q;
    right_d = right_q;
    if (good) begin
      case (pay_q[0])
        CMD_FRONT: front_d = value;
        CMD_LEFT:  left_d  = value;
        CMD_RIGHT: right_d = value;
        default:   ;
      endcase
    end
  end

  assign result_o.command        = pay_q[0];
  assign result_o.value          = value;
  assign result_o.front_distance = front_d;
  assign result_o.left_distance  = left_d;
  assign result_o.right_distance = right_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      front_q <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      front_q <= front_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  // payload store, written only in its own phase
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      case (phase_q)
        PH_B1:   pay_q[0] <= b;
        PH_B2:   pay_q[1] <= b;
        PH_B3:   pay_q[2] <= b;
        PH_B4:   pay_q[3] <= b;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ssfd_out_reg.sv =====
// Result register holding one item until the receiver takes it.
// Depends on ssfd_pkg.
module ssfd_out_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  ssfd_pkg::result_t          result_i,
  output logic                       free_o,   // may load this cycle
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [ssfd_pkg::RES_W-1:0] m_data_o
);
  import ssfd_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign free_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for start_stop_frame_deframer_top: byte stream in, frame results out.
// Needs ssfd_pkg and the deframer RTL; predicts every frame result internally.
module tb;
  import ssfd_pkg::*;

  localparam logic [7:0] SIX_BIT_MASK = 8'h3F;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  // slave side: one rx_byte per item
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  // master side: one frame result per item
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  start_stop_frame_deframer_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // stimulus and traffic shaping
  logic [7:0] rx_byte_q [$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  logic        byte_taken = 1'b0;

  // predictor state
  phase_e      rx_phase = PH_IDLE;
  logic [7:0]  payload_q [4] = '{default: '0};
  logic [15:0] front_q = '0;
  logic [15:0] left_q = '0;
  logic [15:0] right_q = '0;
  result_t     expected_frames_q [$];
  int unsigned mismatch_cnt = 0;

  // Advance the frame tracker by one byte; queue a result on a good frame.
  task automatic deframe_rx_byte(input logic [7:0] b);
    result_t     res;
    logic [15:0] val;
    case (rx_phase)
      PH_B1, PH_B2, PH_B3, PH_B4: begin
        payload_q[2'(rx_phase - 3'd1)] = b;
        rx_phase = phase_e'(rx_phase + 3'd1);
      end
      PH_STOP: begin
        if (b == STOP_BYTE && payload_q[1][MARKER_BIT]) begin
          // b4 and the six low bits of b3 overlap at bits 6..7 (OR'd), b2 bits truncate
          val = 16'(payload_q[3])
              | (16'(payload_q[2] & SIX_BIT_MASK) << 6)
              | (16'(payload_q[1] & SIX_BIT_MASK) << 12);
          if (payload_q[0] == CMD_FRONT) front_q = val;
          else if (payload_q[0] == CMD_LEFT) left_q = val;
          else if (payload_q[0] == CMD_RIGHT) right_q = val;
          res.command        = payload_q[0];
          res.value          = val;
          res.front_distance = front_q;
          res.left_distance  = left_q;
          res.right_distance = right_q;
          expected_frames_q.push_back(res);
        end
        rx_phase = PH_IDLE;
      end
      default: begin
        rx_phase = PH_IDLE;
      end
    endcase
    // a start byte restarts capture from any phase, even after being stored
    if (b == START_BYTE) rx_phase = PH_B1;
  endtask

  task automatic queue_frame(input logic lead_start, input logic [7:0] cmd,
                             input logic [7:0] b2, input logic [7:0] b3,
                             input logic [7:0] b4, input logic [7:0] stop);
    if (lead_start) rx_byte_q.push_back(START_BYTE);
    rx_byte_q.push_back(cmd);
    rx_byte_q.push_back(b2);
    rx_byte_q.push_back(b3);
    rx_byte_q.push_back(b4);
    rx_byte_q.push_back(stop);
  endtask

  // Mostly well-formed frames with random content, plus truncated frames and noise.
  task automatic queue_random_bytes(input int n);
    int         pushed;
    int         kind;
    int         len;
    logic [7:0] cmd;
    logic [7:0] b2;
    logic [7:0] stop;
    pushed = 0;
    while (pushed < n) begin
      kind = $urandom_range(99);
      if (kind < 72) begin
        case ($urandom_range(3))
          0: cmd = CMD_FRONT;
          1: cmd = CMD_LEFT;
          2: cmd = CMD_RIGHT;
          default: cmd = 8'($urandom);
        endcase
        b2 = 8'($urandom);
        if ($urandom_range(9) != 0) b2[MARKER_BIT] = 1'b1;
        stop = ($urandom_range(19) != 0) ? STOP_BYTE : 8'($urandom);
        queue_frame(1'b1, cmd, b2, 8'($urandom), 8'($urandom), stop);
        pushed += 6;
      end else if (kind < 86) begin
        // frame cut short; the next start byte takes over
        rx_byte_q.push_back(START_BYTE);
        len = $urandom_range(1, 4);
        repeat (len) rx_byte_q.push_back(8'($urandom));
        pushed += len + 1;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) rx_byte_q.push_back(8'($urandom));
        pushed += len;
      end
    end
  endtask

  task automatic wait_all_done();
    while (rx_byte_q.size() != 0 || s_axis_tvalid || expected_frames_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Long receiver hold-off, counted here; requests come from the sequence block.
  always @(negedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= LONG_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Driver: inputs change on the falling edge only.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || byte_taken) begin
        if (rx_byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tdata  <= rx_byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: sample both channels at the rising edge.
  always @(posedge clk_i) begin : monitor_blk
    result_t got;
    result_t want;
    byte_taken = s_axis_tvalid && s_axis_tready;
    if (byte_taken) deframe_rx_byte(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_frames_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: cmd=%h value=%h front=%h left=%h right=%h",
                   got.command, got.value, got.front_distance, got.left_distance,
                   got.right_distance);
      end else begin
        want = expected_frames_q.pop_front();
        if (got.command !== want.command || got.value !== want.value ||
            got.front_distance !== want.front_distance ||
            got.left_distance !== want.left_distance ||
            got.right_distance !== want.right_distance) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("mismatch: cmd %h/%h value %h/%h front %h/%h left %h/%h right %h/%h",
                     want.command, got.command, want.value, got.value,
                     want.front_distance, got.front_distance,
                     want.left_distance, got.left_distance,
                     want.right_distance, got.right_distance);
        end
      end
    end
  end

  // Sequence: directed frames, then four random phases with different idling.
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // stop slot carries a start byte: frame dropped, capture restarts
    queue_frame(1'b1, CMD_FRONT, 8'h7F, 8'h3F, 8'hFE, START_BYTE);
    // continues the restarted frame; front gets 0xFFFE
    queue_frame(1'b0, CMD_FRONT, 8'h7F, 8'h3F, 8'hFE, STOP_BYTE);
    queue_frame(1'b1, CMD_LEFT, 8'h40, 8'h00, 8'h00, STOP_BYTE);
    // marker bit clear: no result
    queue_frame(1'b1, CMD_RIGHT, 8'h3F, 8'h12, 8'h34, STOP_BYTE);
    // start byte inside payload restarts the frame
    rx_byte_q.push_back(START_BYTE);
    rx_byte_q.push_back(CMD_RIGHT);
    rx_byte_q.push_back(8'hC0);
    rx_byte_q.push_back(START_BYTE);
    queue_frame(1'b0, CMD_RIGHT, 8'h41, 8'h55, 8'hAA, STOP_BYTE);
    // other command: bad stop drops it, good stop emits it
    queue_frame(1'b1, 8'h80, 8'hC1, 8'h01, 8'h02, 8'h00);
    queue_frame(1'b1, 8'h80, 8'hC1, 8'h01, 8'h02, STOP_BYTE);
    wait_all_done();

    // no idling, with one long receiver hold-off to back up the input
    queue_random_bytes(340);
    hold_reqs++;
    wait_all_done();

    src_idle_pct = 56;
    queue_random_bytes(170);
    wait_all_done();
    queue_random_bytes(170);
    wait_all_done();

    src_idle_pct = 0;
    snk_stall_pct = 56;
    queue_random_bytes(340);
    wait_all_done();

    src_idle_pct = 11;
    snk_stall_pct = 11;
    queue_random_bytes(340);
    wait_all_done();

    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_frames_q.size() == 0) begin
      $display("[start_stop_frame_deframer_top] OK");
    end else begin
      $display("[start_stop_frame_deframer_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[start_stop_frame_deframer_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ssfd_pkg.sv
rtl/core/ssfd_in_reg.sv
rtl/core/ssfd_core.sv
rtl/core/ssfd_out_reg.sv
rtl/core/start_stop_frame_deframer_top.sv
bench/tb.sv
